/* sv/ppt_pkg.sv */
// Shared types and constants for the pedal plausibility and torque block.
// No dependencies; the channel interfaces and the top level import it.
package ppt_pkg;

	localparam int ADC_W    = 10;
	localparam int TORQ_W   = 8;
	localparam int PCT_REG_W = 7;
	localparam int TIME_W   = 16;
	localparam int POWER_W  = 18;
	localparam int PCT_W    = 15;   // Q7.8 percent, 0..25600
	localparam int SUM_W    = 16;   // sum of both percents, 0..51200
	localparam int CUR_W    = 8;    // pack current after the limit, 0..200
	localparam int CFG_AW   = 5;
	localparam int CFG_DW   = 32;

	// Sensor bands and calibration ranges.
	localparam logic [ADC_W-1:0] A_CAL_MIN    = 10'd330;
	localparam logic [ADC_W-1:0] A_CAL_MAX    = 10'd850;
	localparam logic [ADC_W-1:0] B_CAL_MIN    = 10'd310;
	localparam logic [ADC_W-1:0] B_CAL_MAX    = 10'd830;
	localparam logic [ADC_W-1:0] BRK_CAL_MIN  = 10'd40;
	localparam logic [ADC_W-1:0] BRK_CAL_MAX  = 10'd630;
	localparam logic [ADC_W-1:0] THR_BAND_MIN = 10'd50;
	localparam logic [ADC_W-1:0] THR_BAND_MAX = 10'd1000;
	localparam logic [ADC_W-1:0] BRK_BAND_MIN = 10'd10;
	localparam logic [ADC_W-1:0] BRK_BAND_MAX = 10'd1000;
	localparam logic [ADC_W-1:0] CURRENT_LIMIT = 10'd200;
	localparam logic [SUM_W-1:0] LOW_SUM      = 16'd2560;
	localparam logic [SUM_W-1:0] HIGH_SUM     = 16'd12800;

	// Percent = x*25600/520 = x*640/13; the divide by 13 is a reciprocal
	// multiply, exact for every product up to 520*640.
	localparam logic [20:0] RECIP13    = 21'd1290556;
	localparam int          RECIP13_SH = 24;
	// Torque = (torque_max*sum >> 10) / 50, again by reciprocal.
	localparam logic [14:0] RECIP50    = 15'd20972;
	localparam int          RECIP50_SH = 20;

	typedef enum logic [2:0] {
		REG_TORQUE_MAX    = 3'd0,
		REG_MISMATCH_PCT  = 3'd1,
		REG_MISMATCH_TIME = 3'd2,
		REG_BRAKE_TIME    = 3'd3,
		REG_BRAKE_LEVEL   = 3'd4,
		REG_POWER_LEVEL   = 3'd5
	} reg_idx_t;

endpackage

/* sv/ppt_sample_if.sv */
// Sample channel: valid/ready handshake with the sensor readings as payload.
// Depends on ppt_pkg for the field widths.
interface ppt_sample_if;
	import ppt_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADC_W-1:0]  throttle_a;
	logic [ADC_W-1:0]  throttle_b;
	logic [ADC_W-1:0]  brake_raw;
	logic [ADC_W-1:0]  pack_current;
	logic [ADC_W-1:0]  volt_left;
	logic [ADC_W-1:0]  volt_right;
	logic [ADC_W-1:0]  elapsed_ms;

	modport source (output valid, throttle_a, throttle_b, brake_raw, pack_current,
		volt_left, volt_right, elapsed_ms, input ready);
	modport sink (input valid, throttle_a, throttle_b, brake_raw, pack_current,
		volt_left, volt_right, elapsed_ms, output ready);
endinterface

/* sv/ppt_result_if.sv */
// Result channel: valid/ready handshake with the torque command and flags.
// Depends on ppt_pkg for the field widths.
interface ppt_result_if;
	import ppt_pkg::*;

	logic              valid;
	logic              ready;
	logic [TORQ_W-1:0] torque_cmd;
	logic              brake_light_on;
	logic              sensors_valid;
	logic              mismatch_active;
	logic              brake_cut_latched;

	modport source (output valid, torque_cmd, brake_light_on, sensors_valid,
		mismatch_active, brake_cut_latched, input ready);
	modport sink (input valid, torque_cmd, brake_light_on, sensors_valid,
		mismatch_active, brake_cut_latched, output ready);
endinterface

/* sv/pedal_plausibility_torque_top.sv */
// Pedal plausibility check and torque command, top level.
// Depends on ppt_pkg, ppt_sample_if and ppt_result_if.
//
// One sample transaction on the samples channel yields exactly one result
// transaction on the results channel, in order. Both use valid/ready; a
// transaction completes on a clock edge with valid and ready high.
// The six calibration registers sit on the APB port at byte address 4*index;
// pready is always high and reads return the register value. Registers are
// meant to be written only while no sample is in flight.
// The edge that takes the sample loads the input register; the result then
// moves through the stage 2, stage 3 and output registers (percent and power
// multiply, plausibility state update with the torque multiply, torque scaling
// into the output register). One sample per cycle while the receiver is ready.
// The plausibility timers and flags are updated as a sample leaves the
// second stage, so the next sample sees the new state.
// When the receiver stalls, the stages fill up behind the output register
// and samples.ready drops only once every stage holds a sample.
// Reset clears the pipeline, the plausibility state and loads the register
// defaults; the block accepts samples as soon as reset is released.
module pedal_plausibility_torque_top (
	input  logic                        clk,
	input  logic                        arst_n,
	ppt_sample_if.sink                  samples,
	ppt_result_if.source                results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ppt_pkg::CFG_AW-1:0]  paddr,
	input  logic [ppt_pkg::CFG_DW-1:0]  pwdata,
	output logic [ppt_pkg::CFG_DW-1:0]  prdata,
	output logic                        pready
);
	import ppt_pkg::*;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
		input logic [ADC_W-1:0] d);
		logic [TIME_W:0] s;
		s = {1'b0, t} + {{(TIME_W+1-ADC_W){1'b0}}, d};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

	// ---------------- configuration registers ----------------
	logic [TORQ_W-1:0]    torque_max_q;
	logic [PCT_REG_W-1:0] mismatch_pct_q;
	logic [TIME_W-1:0]    mismatch_time_q;
	logic [TIME_W-1:0]    brake_time_q;
	logic [ADC_W-1:0]     brake_level_q;
	logic [POWER_W-1:0]   power_level_q;
	logic                 cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			torque_max_q    <= 8'd20;
			mismatch_pct_q  <= 7'd10;
			mismatch_time_q <= 16'd100;
			brake_time_q    <= 16'd500;
			brake_level_q   <= 10'd170;
			power_level_q   <= 18'd5000;
		end else if (cfg_wr) begin
			case (paddr[CFG_AW-1:2])
				REG_TORQUE_MAX:    torque_max_q    <= pwdata[TORQ_W-1:0];
				REG_MISMATCH_PCT:  mismatch_pct_q  <= pwdata[PCT_REG_W-1:0];
				REG_MISMATCH_TIME: mismatch_time_q <= pwdata[TIME_W-1:0];
				REG_BRAKE_TIME:    brake_time_q    <= pwdata[TIME_W-1:0];
				REG_BRAKE_LEVEL:   brake_level_q   <= pwdata[ADC_W-1:0];
				REG_POWER_LEVEL:   power_level_q   <= pwdata[POWER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[CFG_AW-1:2])
			REG_TORQUE_MAX:    prdata = {{(CFG_DW-TORQ_W){1'b0}}, torque_max_q};
			REG_MISMATCH_PCT:  prdata = {{(CFG_DW-PCT_REG_W){1'b0}}, mismatch_pct_q};
			REG_MISMATCH_TIME: prdata = {{(CFG_DW-TIME_W){1'b0}}, mismatch_time_q};
			REG_BRAKE_TIME:    prdata = {{(CFG_DW-TIME_W){1'b0}}, brake_time_q};
			REG_BRAKE_LEVEL:   prdata = {{(CFG_DW-ADC_W){1'b0}}, brake_level_q};
			REG_POWER_LEVEL:   prdata = {{(CFG_DW-POWER_W){1'b0}}, power_level_q};
			default:           prdata = '0;
		endcase
	end

	// ---------------- pipeline flow control ----------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4 = !v_s4 || results.ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign samples.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= samples.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// ---------------- stage 1: input register ----------------
	logic [ADC_W-1:0] a_s1, b_s1, brk_s1, cur_s1, vl_s1, vr_s1, el_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && samples.valid) begin
			a_s1   <= samples.throttle_a;
			b_s1   <= samples.throttle_b;
			brk_s1 <= samples.brake_raw;
			cur_s1 <= samples.pack_current;
			vl_s1  <= samples.volt_left;
			vr_s1  <= samples.volt_right;
			el_s1  <= samples.elapsed_ms;
		end
	end

	// Band check, calibration clamp and the percent and power products.
	logic             band_ok;
	logic [ADC_W-1:0] a_c, b_c, brk_c, xa, xb, vmax;
	logic [18:0]      ya, yb;
	logic [39:0]      pa_prod, pb_prod;
	logic [CUR_W-1:0] cur_lim;
	logic [POWER_W-1:0] power;

	assign band_ok = (a_s1 inside {[THR_BAND_MIN:THR_BAND_MAX]}) &&
		(b_s1 inside {[THR_BAND_MIN:THR_BAND_MAX]}) &&
		(brk_s1 inside {[BRK_BAND_MIN:BRK_BAND_MAX]});

	assign a_c   = (a_s1 < A_CAL_MIN) ? A_CAL_MIN : ((a_s1 > A_CAL_MAX) ? A_CAL_MAX : a_s1);
	assign b_c   = (b_s1 < B_CAL_MIN) ? B_CAL_MIN : ((b_s1 > B_CAL_MAX) ? B_CAL_MAX : b_s1);
	assign brk_c = (brk_s1 < BRK_CAL_MIN) ? BRK_CAL_MIN :
		((brk_s1 > BRK_CAL_MAX) ? BRK_CAL_MAX : brk_s1);

	assign xa = a_c - A_CAL_MIN;
	assign xb = b_c - B_CAL_MIN;
	// x*640 = (x << 9) + (x << 7)
	assign ya = {xa, 9'b0} + {2'b0, xa, 7'b0};
	assign yb = {xb, 9'b0} + {2'b0, xb, 7'b0};
	assign pa_prod = {21'b0, ya} * {19'b0, RECIP13};
	assign pb_prod = {21'b0, yb} * {19'b0, RECIP13};

	assign cur_lim = (cur_s1 > CURRENT_LIMIT) ? '0 : cur_s1[CUR_W-1:0];
	assign vmax    = (vl_s1 > vr_s1) ? vl_s1 : vr_s1;
	assign power   = {{(POWER_W-CUR_W){1'b0}}, cur_lim} * {{(POWER_W-ADC_W){1'b0}}, vmax};

	// ---------------- stage 2 ----------------
	logic [PCT_W-1:0]   pa_s2, pb_s2;
	logic [POWER_W-1:0] power_s2;
	logic               braked_s2, ok_s2;
	logic [ADC_W-1:0]   el_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			pa_s2     <= pa_prod[RECIP13_SH+PCT_W-1:RECIP13_SH];
			pb_s2     <= pb_prod[RECIP13_SH+PCT_W-1:RECIP13_SH];
			power_s2  <= power;
			braked_s2 <= brk_c > brake_level_q;
			ok_s2     <= band_ok;
			el_s2     <= el_s1;
		end
	end

	// Plausibility state; it advances as a sample moves from stage 2 to 3.
	logic              mismatch_flag_q, conflict_flag_q, cut_latch_q, light_q;
	logic [TIME_W-1:0] mismatch_timer_q, conflict_timer_q;

	logic              mf_d, cf_d, latch_d, light_d, cut;
	logic [TIME_W-1:0] mt_d, ct_d;
	logic [SUM_W-1:0]  sum;
	logic [PCT_W-1:0]  diff, thr;
	logic              low, high, pow_lt, pow_gt;
	logic [23:0]       tq_prod;

	assign sum    = {1'b0, pa_s2} + {1'b0, pb_s2};
	assign diff   = (pa_s2 > pb_s2) ? (pa_s2 - pb_s2) : (pb_s2 - pa_s2);
	assign thr    = {mismatch_pct_q, 8'b0};
	assign low    = sum < LOW_SUM;
	assign high   = sum > HIGH_SUM;
	assign pow_lt = power_s2 < power_level_q;
	assign pow_gt = power_s2 > power_level_q;
	assign tq_prod = {16'b0, torque_max_q} * {8'b0, sum};

	always_comb begin
		mt_d    = mismatch_flag_q ? sat_add(mismatch_timer_q, el_s2) : mismatch_timer_q;
		ct_d    = conflict_flag_q ? sat_add(conflict_timer_q, el_s2) : conflict_timer_q;
		mf_d    = mismatch_flag_q;
		cf_d    = conflict_flag_q;
		latch_d = cut_latch_q;
		light_d = light_q;
		cut     = 1'b0;
		if (!ok_s2) begin
			cut = 1'b1;
		end else begin
			light_d = braked_s2;
			// A difference exactly at the limit leaves the mismatch state alone.
			if (mismatch_flag_q && diff < thr) begin
				mf_d = 1'b0;
				mt_d = '0;
			end else if (diff > thr) begin
				mf_d = 1'b1;
				if (mt_d > mismatch_time_q) cut = 1'b1;
			end
			// Pedal released with little power clears the brake conflict.
			if (low && pow_lt && conflict_flag_q) begin
				ct_d    = '0;
				cf_d    = 1'b0;
				latch_d = 1'b0;
				cut     = 1'b1;
			end
			if (latch_d) cut = 1'b1;
			if ((high || pow_gt) && braked_s2) begin
				cf_d = 1'b1;
				if (ct_d > brake_time_q) begin
					cut     = 1'b1;
					latch_d = 1'b1;
				end
			end
			if (low) cut = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mismatch_flag_q  <= 1'b0;
			mismatch_timer_q <= '0;
			conflict_flag_q  <= 1'b0;
			conflict_timer_q <= '0;
			cut_latch_q      <= 1'b0;
			light_q          <= 1'b0;
		end else if (v_s2 && rdy3) begin
			mismatch_flag_q  <= mf_d;
			mismatch_timer_q <= mt_d;
			conflict_flag_q  <= cf_d;
			conflict_timer_q <= ct_d;
			cut_latch_q      <= latch_d;
			light_q          <= light_d;
		end
	end

	// ---------------- stage 3 ----------------
	logic [13:0] q_s3;
	logic        cut_s3, light_s3, ok_s3, mf_s3, latch_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			q_s3     <= tq_prod[23:10];
			cut_s3   <= cut;
			light_s3 <= light_d;
			ok_s3    <= ok_s2;
			mf_s3    <= mf_d;
			latch_s3 <= latch_d;
		end
	end

	logic [28:0] scale_prod;

	assign scale_prod = {15'b0, q_s3} * {14'b0, RECIP50};

	// ---------------- stage 4: output register ----------------
	logic [TORQ_W-1:0] torque_s4;
	logic              light_s4, ok_s4, mf_s4, latch_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			torque_s4 <= cut_s3 ? '0 : scale_prod[RECIP50_SH+TORQ_W-1:RECIP50_SH];
			light_s4  <= light_s3;
			ok_s4     <= ok_s3;
			mf_s4     <= mf_s3;
			latch_s4  <= latch_s3;
		end
	end

	assign results.valid             = v_s4;
	assign results.torque_cmd        = torque_s4;
	assign results.brake_light_on    = light_s4;
	assign results.sensors_valid     = ok_s4;
	assign results.mismatch_active   = mf_s4;
	assign results.brake_cut_latched = latch_s4;

endmodule

/* tb/sv/pedal_plausibility_torque_top_tb.sv */
// Self-checking testbench for pedal_plausibility_torque_top: directed samples, then random drive
// scenes under several register settings and idle patterns, checked against a behavioral model.
// Depends on ppt_pkg, ppt_sample_if, ppt_result_if and the top level.
module pedal_plausibility_torque_top_tb;
	import ppt_pkg::*;

	localparam int unsigned PCT_SCALE      = 25600;
	localparam int unsigned TORQUE_DIV     = 51200;
	localparam int unsigned MS_MAX         = 65535;
	localparam int          PIPE_LATENCY   = 4;
	localparam int          END_WAIT       = 20;
	localparam int          WATCHDOG_LIMIT = 1000;
	localparam int          NUM_PHASES     = 8;
	localparam int          PHASE_SAMPLES  = 220;
	localparam int          NPLAN          = 22;

	typedef struct packed {
		logic [ADC_W-1:0] throttle_a;
		logic [ADC_W-1:0] throttle_b;
		logic [ADC_W-1:0] brake_raw;
		logic [ADC_W-1:0] pack_current;
		logic [ADC_W-1:0] volt_left;
		logic [ADC_W-1:0] volt_right;
		logic [ADC_W-1:0] elapsed_ms;
	} sample_t;

	typedef struct packed {
		logic [TORQ_W-1:0] torque_cmd;
		logic              brake_light_on;
		logic              sensors_valid;
		logic              mismatch_active;
		logic              brake_cut_latched;
	} cmd_t;

	typedef struct packed {
		sample_t smp;
		bit      typed;
		cmd_t    want;
	} plan_row_t;

	typedef enum {CRUISE, BRAKE_FIGHT, RELEASE, SPLIT} scene_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic pready;

	ppt_sample_if samp();
	ppt_result_if res();

	pedal_plausibility_torque_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samp),
		.results (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Register copies and plausibility state of the behavioral model.
	int unsigned cfg_torque_max = 20;
	int unsigned cfg_mismatch_pct = 10;
	int unsigned cfg_mismatch_time = 100;
	int unsigned cfg_brake_time = 500;
	int unsigned cfg_brake_level = 170;
	int unsigned cfg_power_level = 5000;
	bit          mm_flag = 0;
	int unsigned mm_timer = 0;
	bit          cf_flag = 0;
	int unsigned cf_timer = 0;
	bit          cut_held = 0;
	bit          light_held = 0;

	cmd_t   pending_cmds[$];
	int     faults = 0;
	int     quiet_cycles = 0;
	int     tx_idle_pct = 0;
	int     rx_stall_pct = 0;
	scene_t scene = CRUISE;

	// Directed samples: out-of-band readings, calibration extremes, both timed checks.
	plan_row_t plan [NPLAN] = '{
		'{'{0, 500, 100, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0}},
		'{'{1023, 600, 300, 1023, 1023, 1023, 1023}, 1, '{0, 0, 0, 0, 0}},
		'{'{500, 49, 100, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0}},
		'{'{500, 1001, 100, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0}},
		'{'{500, 500, 9, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0}},
		'{'{500, 500, 1001, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0}},
		'{'{850, 830, 40, 0, 0, 0, 10}, 1, '{20, 0, 1, 0, 0}},
		'{'{1000, 1000, 10, 0, 0, 0, 0}, 1, '{20, 0, 1, 0, 0}},
		'{'{330, 310, 40, 0, 0, 0, 0}, 1, '{0, 0, 1, 0, 0}},
		'{'{50, 50, 1000, 0, 0, 0, 0}, 1, '{0, 1, 1, 0, 0}},
		'{'{850, 310, 40, 0, 0, 0, 0}, 1, '{10, 0, 1, 1, 0}},
		'{'{850, 310, 40, 0, 0, 0, 1023}, 0, '{0, 0, 0, 0, 0}},
		'{'{0, 500, 100, 0, 0, 0, 5}, 0, '{0, 0, 0, 0, 0}},
		'{'{434, 362, 40, 0, 0, 0, 1}, 0, '{0, 0, 0, 0, 0}},
		'{'{850, 830, 40, 0, 0, 0, 3}, 0, '{0, 0, 0, 0, 0}},
		'{'{434, 362, 40, 0, 0, 0, 1}, 0, '{0, 0, 0, 0, 0}},
		'{'{850, 830, 630, 1023, 1023, 0, 600}, 0, '{0, 0, 0, 0, 0}},
		'{'{850, 830, 630, 1023, 1023, 0, 600}, 0, '{0, 0, 0, 0, 0}},
		'{'{600, 580, 40, 0, 0, 0, 20}, 0, '{0, 0, 0, 0, 0}},
		'{'{330, 310, 40, 0, 0, 0, 0}, 0, '{0, 0, 0, 0, 0}},
		'{'{330, 310, 500, 200, 100, 300, 0}, 0, '{0, 0, 0, 0, 0}},
		'{'{330, 310, 500, 201, 100, 300, 0}, 0, '{0, 0, 0, 0, 0}}
	};

	function automatic int unsigned sat_ms(int unsigned v);
		return (v > MS_MAX) ? MS_MAX : v;
	endfunction

	function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Advances the model by one sample and returns the torque command it produces.
	function automatic cmd_t predict_cmd(sample_t s);
		int unsigned a, b, brk, cur, vmax, pa, pb, sum, diff, thr, power, torque;
		bit braked, low_thr;
		cmd_t r;
		a = s.throttle_a;
		b = s.throttle_b;
		brk = s.brake_raw;
		cur = s.pack_current;
		vmax = (s.volt_left > s.volt_right) ? s.volt_left : s.volt_right;
		torque = 0;
		if (mm_flag)
			mm_timer = sat_ms(mm_timer + s.elapsed_ms);
		if (cf_flag)
			cf_timer = sat_ms(cf_timer + s.elapsed_ms);
		r.sensors_valid = !(a < THR_BAND_MIN || a > THR_BAND_MAX || b < THR_BAND_MIN ||
			b > THR_BAND_MAX || brk < BRK_BAND_MIN || brk > BRK_BAND_MAX);
		if (r.sensors_valid) begin
			a = clip(a, A_CAL_MIN, A_CAL_MAX);
			b = clip(b, B_CAL_MIN, B_CAL_MAX);
			brk = clip(brk, BRK_CAL_MIN, BRK_CAL_MAX);
			pa = (a - A_CAL_MIN) * PCT_SCALE / (A_CAL_MAX - A_CAL_MIN);
			pb = (b - B_CAL_MIN) * PCT_SCALE / (B_CAL_MAX - B_CAL_MIN);
			sum = pa + pb;
			low_thr = sum < LOW_SUM;
			braked = brk > cfg_brake_level;
			light_held = braked;
			torque = cfg_torque_max * sum / TORQUE_DIV;

			// A difference exactly at the limit leaves the mismatch state alone.
			diff = (pa > pb) ? pa - pb : pb - pa;
			thr = cfg_mismatch_pct * 256;
			if (mm_flag && diff < thr) begin
				mm_flag = 0;
				mm_timer = 0;
			end else if (diff > thr) begin
				mm_flag = 1;
				if (mm_timer > cfg_mismatch_time)
					torque = 0;
			end

			if (cur > CURRENT_LIMIT)
				cur = 0;
			power = cur * vmax;
			if (low_thr && power < cfg_power_level && cf_flag) begin
				cf_timer = 0;
				cf_flag = 0;
				cut_held = 0;
				torque = 0;
			end
			if (cut_held)
				torque = 0;
			if ((sum > HIGH_SUM || power > cfg_power_level) && braked) begin
				cf_flag = 1;
				if (cf_timer > cfg_brake_time) begin
					torque = 0;
					cut_held = 1;
				end
			end
			if (low_thr)
				torque = 0;
		end
		r.torque_cmd = torque[TORQ_W-1:0];
		r.brake_light_on = light_held;
		r.mismatch_active = mm_flag;
		r.brake_cut_latched = cut_held;
		return r;
	endfunction

	// Random samples follow a drive scene that changes now and then; a tenth are pure noise.
	function automatic sample_t next_sample();
		sample_t s;
		int unsigned a;
		int roll;
		if ($urandom_range(0, 15) == 0)
			scene = scene_t'($urandom_range(0, 3));
		s.volt_left = $urandom_range(0, 1023);
		s.volt_right = $urandom_range(0, 1023);
		roll = $urandom_range(0, 99);
		if (roll < 70)
			s.elapsed_ms = $urandom_range(0, 40);
		else if (roll < 95)
			s.elapsed_ms = $urandom_range(0, 300);
		else
			s.elapsed_ms = $urandom_range(0, 1023);
		if ($urandom_range(0, 9) == 0) begin
			s.throttle_a = $urandom_range(0, 1023);
			s.throttle_b = $urandom_range(0, 1023);
			s.brake_raw = $urandom_range(0, 1023);
			s.pack_current = $urandom_range(0, 1023);
			return s;
		end
		case (scene)
			CRUISE: begin
				a = $urandom_range(300, 880);
				s.throttle_a = a;
				s.throttle_b = a - 40 + $urandom_range(0, 40);
				s.brake_raw = $urandom_range(10, 160);
				s.pack_current = $urandom_range(0, 200);
			end
			BRAKE_FIGHT: begin
				a = $urandom_range(500, 1000);
				s.throttle_a = a;
				s.throttle_b = a - 40 + $urandom_range(0, 40);
				s.brake_raw = $urandom_range(300, 1000);
				s.pack_current = $urandom_range(0, 250);
			end
			RELEASE: begin
				s.throttle_a = $urandom_range(50, 345);
				s.throttle_b = $urandom_range(50, 320);
				s.brake_raw = $urandom_range(10, 1000);
				s.pack_current = $urandom_range(0, 15);
			end
			default: begin
				s.throttle_a = $urandom_range(50, 1000);
				s.throttle_b = $urandom_range(50, 1000);
				s.brake_raw = $urandom_range(10, 1000);
				s.pack_current = $urandom_range(0, 1023);
			end
		endcase
		return s;
	endfunction

	task automatic write_reg(reg_idx_t idx, int unsigned val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TORQUE_MAX:    cfg_torque_max = val & 32'hFF;
			REG_MISMATCH_PCT:  cfg_mismatch_pct = val & 32'h7F;
			REG_MISMATCH_TIME: cfg_mismatch_time = val & 32'hFFFF;
			REG_BRAKE_TIME:    cfg_brake_time = val & 32'hFFFF;
			REG_BRAKE_LEVEL:   cfg_brake_level = val & 32'h3FF;
			REG_POWER_LEVEL:   cfg_power_level = val & 32'h3FFFF;
			default: ;
		endcase
	endtask

	// Returns at the clock edge that completes the sample transaction.
	task automatic send_sample(sample_t s);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			samp.valid <= 1'b0;
			@(posedge clk);
		end
		samp.valid <= 1'b1;
		samp.throttle_a <= s.throttle_a;
		samp.throttle_b <= s.throttle_b;
		samp.brake_raw <= s.brake_raw;
		samp.pack_current <= s.pack_current;
		samp.volt_left <= s.volt_left;
		samp.volt_right <= s.volt_right;
		samp.elapsed_ms <= s.elapsed_ms;
		do @(posedge clk); while (!(samp.valid && samp.ready));
	endtask

	task automatic drain_pipe(int settle);
		samp.valid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic check_cmd(cmd_t got);
		cmd_t want;
		if (pending_cmds.size() == 0) begin
			$error("result transaction with no command pending");
			faults++;
			return;
		end
		want = pending_cmds.pop_front();
		if (got.torque_cmd !== want.torque_cmd) begin
			$error("torque_cmd: expected %0d, got %0d", want.torque_cmd, got.torque_cmd);
			faults++;
		end
		if (got.brake_light_on !== want.brake_light_on) begin
			$error("brake_light_on: expected %0d, got %0d", want.brake_light_on,
				got.brake_light_on);
			faults++;
		end
		if (got.sensors_valid !== want.sensors_valid) begin
			$error("sensors_valid: expected %0d, got %0d", want.sensors_valid,
				got.sensors_valid);
			faults++;
		end
		if (got.mismatch_active !== want.mismatch_active) begin
			$error("mismatch_active: expected %0d, got %0d", want.mismatch_active,
				got.mismatch_active);
			faults++;
		end
		if (got.brake_cut_latched !== want.brake_cut_latched) begin
			$error("brake_cut_latched: expected %0d, got %0d", want.brake_cut_latched,
				got.brake_cut_latched);
			faults++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			check_cmd(cmd_t'{res.torque_cmd, res.brake_light_on, res.sensors_valid,
				res.mismatch_active, res.brake_cut_latched});
		res.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if ((samp.valid && samp.ready) || (res.valid && res.ready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** pedal_plausibility_torque_top: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		sample_t s;
		cmd_t c;
		int unsigned regs [6];
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		samp.valid <= 1'b0;
		samp.throttle_a <= '0;
		samp.throttle_b <= '0;
		samp.brake_raw <= '0;
		samp.pack_current <= '0;
		samp.volt_left <= '0;
		samp.volt_right <= '0;
		samp.elapsed_ms <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NPLAN; i++) begin
			send_sample(plan[i].smp);
			c = predict_cmd(plan[i].smp);
			pending_cmds.push_back(plan[i].typed ? plan[i].want : c);
		end
		drain_pipe(PIPE_LATENCY);

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: regs = '{20, 10, 100, 500, 170, 5000};
				1: regs = '{255, 0, 0, 0, 0, 0};
				// Percent limit above 100 can never be exceeded by the sensor difference.
				2: regs = '{0, 127, 65535, 65535, 1023, 262143};
				3: regs = '{255, 100, 65535, 0, 1023, 0};
				6: regs = '{128, 5, 50, 200, 300, 40000};
				default: regs = '{$urandom_range(0, 255), $urandom_range(0, 110),
					$urandom_range(0, 2000), $urandom_range(0, 2000),
					$urandom_range(0, 1023), $urandom_range(0, 60000)};
			endcase
			write_reg(REG_TORQUE_MAX, regs[0]);
			write_reg(REG_MISMATCH_PCT, regs[1]);
			write_reg(REG_MISMATCH_TIME, regs[2]);
			write_reg(REG_BRAKE_TIME, regs[3]);
			write_reg(REG_BRAKE_LEVEL, regs[4]);
			write_reg(REG_POWER_LEVEL, regs[5]);
			case (p % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
				default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
			endcase
			for (int n = 0; n < PHASE_SAMPLES; n++) begin
				s = next_sample();
				send_sample(s);
				pending_cmds.push_back(predict_cmd(s));
			end
			drain_pipe(PIPE_LATENCY);
		end

		drain_pipe(END_WAIT);
		if (faults == 0)
			$display("** pedal_plausibility_torque_top: PASSED **");
		else
			$display("** pedal_plausibility_torque_top: FAILED **");
		$finish;
	end

endmodule
